@@ rtl/lbfp_pkg.sv @@
// ----------------------------------------------------------------------------
// lbfp_pkg
// Shared constants, codes and control structs of the bit field packer.
// ----------------------------------------------------------------------------
package lbfp_pkg;

  localparam int MAX_BYTES  = 65536;
  localparam int CNT_W      = $clog2(MAX_BYTES + 1);
  localparam int CAP_W      = 17;
  localparam int EXT_W      = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int CHK_W      = EXT_W + 4;
  localparam int WIDE_LIMIT = 32;
  localparam int ACC_W      = 39;
  localparam int ADDR_W     = 3;

  localparam logic [CAP_W-1:0] CAP_RESET  = 17'd65536;
  localparam logic [7:0]       GROUP_MORE = 8'h80;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_ALIGN   = 2'd1,
    ACT_VARINT  = 2'd2,
    ACT_RESTART = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT
  } state_t;

  typedef enum logic {
    REG_CAPACITY = 1'b0,
    REG_LIMIT    = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CAP_W-1:0] capacity;
    logic             limit_en;
  } cfg_t;

  typedef struct packed {
    logic latch;
    logic put;
    logic emit;
    logic align;
    logic restart;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    count_zero;
    logic    put_ok;
    logic    put_emits;
    logic    partial_nz;
    logic    can_emit;
    logic    emit_done;
    logic    more;
    logic    overflow;
  } sts_t;

endpackage

@@ rtl/lbfp_in_if.sv @@
// ----------------------------------------------------------------------------
// lbfp_in_if
// Input channel: one packing action per transfer.
// ----------------------------------------------------------------------------
interface lbfp_in_if;
  logic                valid;
  logic                ready;
  lbfp_pkg::action_t   action;
  logic [63:0]         data_value;
  logic [5:0]          bit_count;

  modport source (output valid, action, data_value, bit_count, input ready);
  modport sink   (input valid, action, data_value, bit_count, output ready);
endinterface

@@ rtl/lbfp_out_if.sv @@
// ----------------------------------------------------------------------------
// lbfp_out_if
// Output channel: one packed byte per transfer.
// ----------------------------------------------------------------------------
interface lbfp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_item;
  logic       overflow;

  modport source (output valid, out_byte, last_of_item, overflow, input ready);
  modport sink   (input valid, out_byte, last_of_item, overflow, output ready);
endinterface

@@ rtl/lbfp_regs.sv @@
// ----------------------------------------------------------------------------
// lbfp_regs
// APB-style configuration registers: capacity and limit enable.
// ----------------------------------------------------------------------------
module lbfp_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lbfp_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output lbfp_pkg::cfg_t                cfg
);

  logic [lbfp_pkg::CAP_W-1:0] cap_r;
  logic                       lim_r;
  logic                       wr_en;
  lbfp_pkg::reg_idx_t         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = lbfp_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lbfp_pkg::CAP_RESET;
      lim_r <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        lbfp_pkg::REG_CAPACITY: cap_r <= pwdata[lbfp_pkg::CAP_W-1:0];
        lbfp_pkg::REG_LIMIT:    lim_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      lbfp_pkg::REG_CAPACITY: prdata = {{(32-lbfp_pkg::CAP_W){1'b0}}, cap_r};
      lbfp_pkg::REG_LIMIT:    prdata = {31'd0, lim_r};
      default:                prdata = 32'd0;
    endcase
  end

  assign cfg.capacity = cap_r;
  assign cfg.limit_en = lim_r;

endmodule

@@ rtl/lbfp_ctrl.sv @@
// ----------------------------------------------------------------------------
// lbfp_ctrl
// Sequencer: takes one action, runs its bit puts and byte emissions.
// ----------------------------------------------------------------------------
module lbfp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  lbfp_pkg::sts_t  sts,
  output lbfp_pkg::cmd_t  cmd
);

  lbfp_pkg::state_t state_r;
  lbfp_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lbfp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      lbfp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = lbfp_pkg::ST_EXEC;
        end
      end
      lbfp_pkg::ST_EXEC: begin
        unique case (sts.action)
          lbfp_pkg::ACT_WRITE: begin
            if (sts.count_zero) begin
              state_nxt = lbfp_pkg::ST_IDLE;
            end else begin
              cmd.put   = 1'b1;
              state_nxt = (sts.put_ok && sts.put_emits) ? lbfp_pkg::ST_EMIT
                                                        : lbfp_pkg::ST_IDLE;
            end
          end
          lbfp_pkg::ACT_VARINT: begin
            cmd.put   = 1'b1;
            state_nxt = sts.put_ok ? lbfp_pkg::ST_EMIT : lbfp_pkg::ST_IDLE;
          end
          lbfp_pkg::ACT_ALIGN: begin
            if (!sts.partial_nz) begin
              state_nxt = lbfp_pkg::ST_IDLE;
            end else if (sts.can_emit) begin
              cmd.align = 1'b1;
              state_nxt = lbfp_pkg::ST_IDLE;
            end
          end
          lbfp_pkg::ACT_RESTART: begin
            cmd.restart = 1'b1;
            state_nxt   = lbfp_pkg::ST_IDLE;
          end
          default: state_nxt = lbfp_pkg::ST_IDLE;
        endcase
      end
      lbfp_pkg::ST_EMIT: begin
        if (sts.can_emit) begin
          cmd.emit = 1'b1;
          if (sts.emit_done) begin
            state_nxt = sts.more ? lbfp_pkg::ST_EXEC : lbfp_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = lbfp_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ rtl/lbfp_dp.sv @@
// ----------------------------------------------------------------------------
// lbfp_dp
// Datapath: item latch, bit accumulator, capacity check, output register.
// ----------------------------------------------------------------------------
module lbfp_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  lbfp_pkg::cfg_t      cfg,
  input  lbfp_pkg::cmd_t      cmd,
  output lbfp_pkg::sts_t      sts,
  input  lbfp_pkg::action_t   in_action,
  input  logic [63:0]         in_data_value,
  input  logic [5:0]          in_bit_count,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic                out_overflow
);

  localparam int CNT_W = lbfp_pkg::CNT_W;
  localparam int EXT_W = lbfp_pkg::EXT_W;
  localparam int CHK_W = lbfp_pkg::CHK_W;
  localparam int ACC_W = lbfp_pkg::ACC_W;

  lbfp_pkg::action_t  act_r;
  logic [63:0]        val_r;
  logic [5:0]         cnt_r;
  logic [ACC_W-1:0]   acc_r;
  logic [5:0]         tot_r;
  logic [6:0]         pbits_r;
  logic [2:0]         pcnt_r;
  logic [CNT_W-1:0]   bytes_r;
  logic               ovf_r;
  logic               last_put_r;
  logic               more_r;
  logic               ovalid_r;
  logic [7:0]         ob_r;
  logic               olast_r;
  logic               oovf_r;

  logic               is_var;
  logic               grp_final;
  logic [7:0]         grp;
  logic [5:0]         nbits;
  logic [32:0]        mask;
  logic [31:0]        fld;
  logic [EXT_W-1:0]   cap_ext;
  logic [EXT_W-1:0]   cap_c;
  logic [CHK_W-1:0]   lim;
  logic [CHK_W-1:0]   lhs;
  logic [CHK_W-1:0]   lhs_next;
  logic [CNT_W-1:0]   bytes_inc;
  logic               fail;
  logic               next_fail;
  logic               put_ok;
  logic [5:0]         put_tot;
  logic [ACC_W-1:0]   put_acc;
  logic [5:0]         tot_m8;
  logic               emit_done;
  logic               can_emit;

  assign is_var    = (act_r == lbfp_pkg::ACT_VARINT);
  assign grp_final = (val_r[63:7] == 57'd0);
  assign grp       = grp_final ? val_r[7:0] : (lbfp_pkg::GROUP_MORE | {1'b0, val_r[6:0]});
  assign nbits     = is_var ? 6'd8 : cnt_r;
  assign mask      = (33'd1 << nbits) - 33'd1;
  assign fld       = is_var ? {24'd0, grp} : (val_r[31:0] & mask[31:0]);

  assign cap_ext   = EXT_W'(cfg.capacity);
  assign cap_c     = (cap_ext > EXT_W'(lbfp_pkg::MAX_BYTES)) ? EXT_W'(lbfp_pkg::MAX_BYTES)
                                                              : cap_ext;
  assign lim       = CHK_W'({cap_c, 3'b000});
  assign bytes_inc = (bytes_r == CNT_W'(lbfp_pkg::MAX_BYTES)) ? bytes_r
                                                              : bytes_r + CNT_W'(1);
  assign lhs       = CHK_W'({bytes_r, 3'b000}) + CHK_W'(pcnt_r) + CHK_W'(nbits);
  assign lhs_next  = CHK_W'({bytes_inc, 3'b000}) + CHK_W'(pcnt_r) + CHK_W'(8);
  assign fail      = cfg.limit_en && (lhs > lim);
  assign next_fail = cfg.limit_en && (lhs_next > lim);
  assign put_ok    = !ovf_r && !fail;
  assign put_tot   = {3'd0, pcnt_r} + nbits;
  assign put_acc   = {32'd0, pbits_r} | ({7'd0, fld} << pcnt_r);

  assign tot_m8    = tot_r - 6'd8;
  assign emit_done = (tot_r < 6'd16);
  assign can_emit  = !ovalid_r || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r <= in_action;
      val_r <= in_data_value;
      cnt_r <= (in_bit_count > 6'(lbfp_pkg::WIDE_LIMIT)) ? 6'(lbfp_pkg::WIDE_LIMIT)
                                                         : in_bit_count;
    end else if (cmd.put && put_ok && is_var) begin
      val_r <= val_r >> 7;
    end
    if (cmd.put && put_ok) begin
      acc_r      <= put_acc;
      tot_r      <= put_tot;
      last_put_r <= !is_var || grp_final || next_fail;
    end else if (cmd.emit) begin
      acc_r <= acc_r >> 8;
      tot_r <= tot_m8;
    end
    if (cmd.emit) begin
      ob_r    <= acc_r[7:0];
      olast_r <= emit_done && last_put_r;
      oovf_r  <= ovf_r;
    end else if (cmd.align) begin
      ob_r    <= {1'b0, pbits_r};
      olast_r <= 1'b1;
      oovf_r  <= ovf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pbits_r  <= '0;
      pcnt_r   <= '0;
      bytes_r  <= '0;
      ovf_r    <= 1'b0;
      more_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (cmd.emit || cmd.align) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
      if (cmd.restart) begin
        pbits_r <= '0;
        pcnt_r  <= '0;
        bytes_r <= '0;
        ovf_r   <= 1'b0;
        more_r  <= 1'b0;
      end else if (cmd.put && !ovf_r) begin
        if (fail) begin
          ovf_r  <= 1'b1;
          more_r <= 1'b0;
        end else begin
          more_r <= is_var && !grp_final;
          if (put_tot < 6'd8) begin
            pbits_r <= put_acc[6:0];
            pcnt_r  <= put_tot[2:0];
          end
        end
      end else if (cmd.emit) begin
        bytes_r  <= bytes_inc;
        if (emit_done) begin
          pbits_r <= acc_r[14:8];
          pcnt_r  <= tot_m8[2:0];
        end
      end else if (cmd.align) begin
        bytes_r  <= bytes_inc;
        pbits_r  <= '0;
        pcnt_r   <= '0;
      end
    end
  end

  assign sts.action     = act_r;
  assign sts.count_zero = (cnt_r == 6'd0);
  assign sts.put_ok     = put_ok;
  assign sts.put_emits  = (put_tot >= 6'd8);
  assign sts.partial_nz = (pcnt_r != 3'd0);
  assign sts.can_emit   = can_emit;
  assign sts.emit_done  = emit_done;
  assign sts.more       = more_r;
  assign sts.overflow   = ovf_r;

  assign out_valid    = ovalid_r;
  assign out_byte     = ob_r;
  assign out_last     = olast_r;
  assign out_overflow = oovf_r;

endmodule

@@ rtl/lsb_first_bit_field_packer.sv @@
// ----------------------------------------------------------------------------
// lsb_first_bit_field_packer
// Packs bit fields LSB first into a byte stream, with LEB128 varints.
// ----------------------------------------------------------------------------
// in_ch carries one action per transfer: write bits, align, varint, restart.
// out_ch carries each completed byte; last_of_item marks the final byte of
// an action, overflow shows the sticky flag at emission. An action that
// completes no byte gives no transfer on out_ch.
// cfg_* is an APB-style port: capacity at address 0, limit enable at 4.
// One action is in flight at a time. The action is latched in the accept
// cycle and decoded in the next one; a bit write is put into the
// accumulator, then each byte it completes is emitted. A varint runs a
// capacity check and put, then a byte out, for each 7-bit group. Align
// and restart finish in the decode step. The output register takes one
// byte per cycle while out_ch.ready is high. The first byte is put, then
// emitted into the output register; an align writes it when decoded.
// When out_ch.ready is low, the output register holds its byte and the
// sequencer waits; in_ch.ready stays low until the action is finished.
// Reset (rst_n low, synchronous) clears the position, byte count and
// overflow flag, empties the output register and restores capacity 65536
// with the limit off.
// ----------------------------------------------------------------------------
module lsb_first_bit_field_packer (
  input  logic                         clk,
  input  logic                         rst_n,
  lbfp_in_if.sink                      in_ch,
  lbfp_out_if.source                   out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [lbfp_pkg::ADDR_W-1:0]  cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready
);

  lbfp_pkg::cfg_t cfg;
  lbfp_pkg::cmd_t cmd;
  lbfp_pkg::sts_t sts;
  logic           in_ready;

  lbfp_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  lbfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lbfp_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .cmd           (cmd),
    .sts           (sts),
    .in_action     (in_ch.action),
    .in_data_value (in_ch.data_value),
    .in_bit_count  (in_ch.bit_count),
    .out_ready     (out_ch.ready),
    .out_valid     (out_ch.valid),
    .out_byte      (out_ch.out_byte),
    .out_last      (out_ch.last_of_item),
    .out_overflow  (out_ch.overflow)
  );

  assign in_ch.ready = in_ready;

`ifndef SYNTHESIS
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit || cmd.align) |-> sts.can_emit)
    else $error("byte emitted while output register is full");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch |=> !in_ch.ready)
    else $error("new transfer taken while an action is in flight");

  a_ovf_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sts.overflow) |-> $past(cmd.put))
    else $error("overflow set without a bit put");
`endif

endmodule
